// ----- rtl/core/astm_pkg.sv -----
package astm_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 2;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

   typedef struct packed {
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_idx;
      logic [VALUE_W-1:0] wr_data;
      logic               clr_en;
      logic [IDX_W-1:0]   clr_idx;
   } store_cmd_type;

   typedef struct packed {
      logic [VALUE_W-1:0] rd_data;
      logic               rd_vld;
   } store_rsp_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] minimum;
      logic               overflowed;
   } result_type;

   typedef struct packed {
      logic       fire;
      result_type rslt;
   } done_type;

endpackage

// ----- rtl/core/astm_req_if.sv -----
interface astm_req_if import astm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- rtl/core/astm_rsp_if.sv -----
interface astm_rsp_if import astm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [VALUE_W-1:0] minimum;
   logic               overflowed;

   modport source (output valid, output found, output minimum, output overflowed,
                   input ready);
   modport sink   (input valid, input found, input minimum, input overflowed,
                   output ready);
endinterface

// ----- rtl/core/astm_store.sv -----
module astm_store import astm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  store_cmd_type cmd,
   output store_rsp_type rsp
);

   logic [VALUE_W-1:0]  mem [CAPACITY];
   logic [CAPACITY-1:0] vld_ff;
   logic [CAPACITY-1:0] vld_in;
   logic [VALUE_W-1:0]  rd_data_ff;
   logic                rd_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx] <= cmd.wr_data;
      end
      rd_data_ff <= mem[cmd.rd_addr];
   end

   always_comb begin
      vld_in = vld_ff;
      if (cmd.wr_en) begin
         vld_in[cmd.wr_idx] = 1'b1;
      end
      if (cmd.clr_en) begin
         vld_in[cmd.clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[cmd.rd_addr];
      end
   end

   assign rsp.rd_data = rd_data_ff;
   assign rsp.rd_vld  = rd_vld_ff;

   // only free entries get filled
   a_fill_free: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> !vld_ff[cmd.wr_idx])
      else $error("write into occupied entry");

   a_fill_sets: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en && !cmd.clr_en |=> vld_ff[$past(cmd.wr_idx)])
      else $error("valid bit not set after write");

   a_clr_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en && !cmd.wr_en |=> !vld_ff[$past(cmd.clr_idx)])
      else $error("valid bit not cleared after remove");

endmodule

// ----- rtl/core/astm_seq.sv -----
module astm_seq import astm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   astm_req_if.sink      req_bus,
   input  logic          out_busy,
   input  store_rsp_type st_rsp,
   output store_cmd_type st_cmd,
   output done_type      done
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                chk_ff, chk_in;
   logic [IDX_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                have_ff, have_in;
   logic [VALUE_W-1:0]  best_ff, best_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic                ovf_ff, ovf_in;

   logic               is_query;
   logic [VALUE_W-1:0] operand;
   logic               cmp_eq;
   logic               cmp_lt;
   logic               accept;

   // shared compare unit: stored value against search key or running minimum
   assign is_query = (act_ff == ACT_QUERY);
   assign operand  = is_query ? best_ff : val_ff;
   assign cmp_eq   = (st_rsp.rd_data == operand);
   assign cmp_lt   = (st_rsp.rd_data < operand);

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      val_in      = val_ff;
      cnt_in      = cnt_ff;
      chk_in      = 1'b0;
      chk_idx_in  = cnt_ff;
      have_in     = have_ff;
      best_in     = best_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      ovf_in      = ovf_ff;

      st_cmd.rd_addr = cnt_ff;
      st_cmd.wr_en   = 1'b0;
      st_cmd.wr_idx  = free_idx_ff;
      st_cmd.wr_data = val_ff;
      st_cmd.clr_en  = 1'b0;
      st_cmd.clr_idx = hit_idx_ff;

      done.fire            = 1'b0;
      done.rslt.found      = have_ff;
      done.rslt.minimum    = have_ff ? best_ff : '0;
      done.rslt.overflowed = ovf_ff;

      // data phase, one entry behind the address
      if (chk_ff) begin
         if (st_rsp.rd_vld) begin
            if (cmp_eq && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = chk_idx_ff;
            end
            if (is_query && (!have_ff || cmp_lt)) begin
               have_in = 1'b1;
               best_in = st_rsp.rd_data;
            end
         end else if (!free_ff) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in  = req_bus.action;
               val_in  = req_bus.value;
               cnt_in  = '0;
               have_in = 1'b0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               if (req_bus.action == ACT_INSERT || req_bus.action == ACT_REMOVE ||
                   req_bus.action == ACT_QUERY) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            chk_in = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (is_query) begin
               if (!out_busy) begin
                  done.fire = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               if (act_ff == ACT_INSERT && !hit_ff) begin
                  if (free_ff) begin
                     st_cmd.wr_en = 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (act_ff == ACT_REMOVE && hit_ff) begin
                  st_cmd.clr_en = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chk_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         chk_ff   <= chk_in;
         ovf_ff   <= ovf_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      val_ff      <= val_in;
      chk_idx_ff  <= chk_idx_in;
      have_ff     <= have_in;
      best_ff     <= best_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag dropped");

   a_result_needs_room: assert property (@(posedge clock) disable iff (reset)
      done.fire |-> !out_busy && is_query)
      else $error("result issued into a busy output stage");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && cnt_ff == LAST_IDX |=> state_ff == S_DRAIN)
      else $error("scan did not end after last entry");

endmodule

// ----- rtl/core/active_set_min_tracker.sv -----
// Active set of distinct 32-bit values with a minimum query.
// req_bus: one beat per action (insert, remove, query); action code 3 is
//   taken and dropped with no effect.
// rsp_bus: one beat per query: found, minimum (zero when empty) and the
//   sticky overflow flag. Inserts and removes give no beat.
// Each insert, remove or query walks all CAPACITY entries through the
//   single read port of the value memory, one entry per cycle, against the
//   shared compare unit. req_bus ready is low from the accept through the
//   scan, drain and finish states, until the block is idle again. A query
//   result reaches rsp_bus valid in the same cycle that ready returns. An
//   action code 3 leaves the block idle.
// The result sits in an output register; the next item is accepted while
//   it waits. A following query finishes its scan and then holds until the
//   output register is free.
// Reset (synchronous) empties the store and clears the overflow flag; no
//   clearing pass. A dropped insert into a full store sets the overflow
//   flag until the next reset.
module active_set_min_tracker import astm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   astm_req_if.sink  req_bus,
   astm_rsp_if.source rsp_bus
);

   store_cmd_type st_cmd;
   store_rsp_type st_rsp;
   done_type      done;
   logic          out_busy;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               found_ff;
   logic [VALUE_W-1:0] minimum_ff;
   logic               ovf_ff;

   astm_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (st_cmd),
      .rsp   (st_rsp)
   );

   astm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .out_busy (out_busy),
      .st_rsp   (st_rsp),
      .st_cmd   (st_cmd),
      .done     (done)
   );

   assign out_busy = rsp_valid_ff && !rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (done.fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done.fire) begin
         found_ff   <= done.rslt.found;
         minimum_ff <= done.rslt.minimum;
         ovf_ff     <= done.rslt.overflowed;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.found      = found_ff;
   assign rsp_bus.minimum    = minimum_ff;
   assign rsp_bus.overflowed = ovf_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready && req_bus.action == ACT_QUERY |=> !req_bus.ready)
      else $error("ready after accepting a query");

   a_empty_min_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.found |-> rsp_bus.minimum == '0)
      else $error("nonzero minimum on empty set");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done.fire |-> !out_busy)
      else $error("pending result overwritten");

endmodule
